/* rtl/wsm_pkg.sv */
// ----------------------------------------------------------------------------
// wsm_pkg: shared types and constants of the wheel speed mixer
// field widths, mode and register codes, controller to datapath command and
// status structs
// ----------------------------------------------------------------------------
package wsm_pkg;

    // field widths
    localparam int MODE_W     = 2;
    localparam int SPEED_W    = 16;
    localparam int SCALE_W    = 16;
    localparam int WHEEL_W    = 2;
    localparam int CNT_W      = 3;
    localparam int PARAM_W    = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // internal arithmetic widths
    localparam int SUM_W      = 33;   // exact Q9.24 wheel sum
    localparam int MAG_W      = 32;   // magnitude of a wheel sum
    localparam int PROD_W     = 50;   // shared multiplier product
    localparam int FRAC_W     = 12;   // Q4.12 fraction bits
    localparam int QUO_W      = 15;   // candidate scale, always below one
    localparam int DIV_CNT_W  = 4;
    localparam int DIV_STEPS  = 15;

    localparam int WHEEL_SHIFT = 27;  // Q9.24 times Q1.15 back to Q4.12
    localparam int CMD_SHIFT   = 15;  // Q4.12 times Q1.15 back to Q4.12

    localparam logic [SCALE_W-1:0] SCALE_ONE         = 16'h8000;
    localparam logic [SPEED_W-1:0] SPEED_MAX         = 16'h7FFF;
    localparam logic [SPEED_W-1:0] SPEED_MIN         = 16'h8000;
    localparam logic [CNT_W-1:0]   WHEEL_COUNT_RESET = 3'd2;
    localparam logic [PARAM_W-1:0] PARAM_RESET       = 48'h1000_0000_1000;

    typedef enum logic [MODE_W-1:0] {
        MODE_BOTH = 2'd0,
        MODE_FWD  = 2'd1,
        MODE_TURN = 2'd2,
        MODE_STOP = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WHEEL_COUNT = 3'd0,
        REG_WHEEL_0     = 3'd1,
        REG_WHEEL_1     = 3'd2,
        REG_WHEEL_2     = 3'd3,
        REG_WHEEL_3     = 3'd4
    } reg_index_t;

    // operand pair of the shared multiplier
    typedef enum logic [2:0] {
        MUL_FWD   = 3'd0,
        MUL_TURN  = 3'd1,
        MUL_CMDF  = 3'd2,
        MUL_CMDT  = 3'd3,
        MUL_WHEEL = 3'd4
    } mul_sel_t;

    typedef struct packed {
        logic               load;
        logic               acc_fwd;
        logic               acc_sum;
        logic               div_init;
        logic               div_step;
        logic               div_done;
        logic               scale_fwd;
        logic               scale_turn;
        logic               emit;
        mul_sel_t           msel;
        logic [WHEEL_W-1:0] wheel;
    } wsm_cmd_t;

    typedef struct packed {
        logic exceed;
        logic last_wheel;
        logic out_free;
    } wsm_status_t;

endpackage

/* rtl/wsm_if.sv */
// ----------------------------------------------------------------------------
// wsm_if: request channels of the wheel speed mixer
// velocity command channel and per-wheel result channel, valid/ready
// ----------------------------------------------------------------------------
interface wsm_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [wsm_pkg::MODE_W-1:0]          mode;
    logic signed [wsm_pkg::SPEED_W-1:0]  forward_speed;
    logic signed [wsm_pkg::SPEED_W-1:0]  turn_speed;

    modport source (output valid, output mode, output forward_speed, output turn_speed,
                    input ready);
    modport sink   (input valid, input mode, input forward_speed, input turn_speed,
                    output ready);
endinterface

interface wsm_res_if;
    logic                                valid;
    logic                                ready;
    logic [wsm_pkg::WHEEL_W-1:0]         wheel_index;
    logic signed [wsm_pkg::SPEED_W-1:0]  wheel_vel;
    logic                                wheel_enable;
    logic signed [wsm_pkg::SPEED_W-1:0]  command_forward;
    logic signed [wsm_pkg::SPEED_W-1:0]  command_turn;
    logic [wsm_pkg::SCALE_W-1:0]         desat_scale;
    logic                                last;

    modport source (output valid, output wheel_index, output wheel_vel,
                    output wheel_enable, output command_forward, output command_turn,
                    output desat_scale, output last, input ready);
    modport sink   (input valid, input wheel_index, input wheel_vel,
                    input wheel_enable, input command_forward, input command_turn,
                    input desat_scale, input last, output ready);
endinterface

/* rtl/wsm_ctrl.sv */
// ----------------------------------------------------------------------------
// wsm_ctrl: sequencer of the wheel speed mixer
// walks the wheels through sum, limit check, division, command scaling and result phases
// ----------------------------------------------------------------------------
module wsm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wsm_pkg::wsm_status_t status,
    output wsm_pkg::wsm_cmd_t    cmd
);

    localparam int WW = wsm_pkg::WHEEL_W;
    localparam int SW = wsm_pkg::DIV_CNT_W;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_SUM0  = 12'b0000_0000_0010,
        S_SUM1  = 12'b0000_0000_0100,
        S_SUM2  = 12'b0000_0000_1000,
        S_CHECK = 12'b0000_0001_0000,
        S_DIV   = 12'b0000_0010_0000,
        S_MIN   = 12'b0000_0100_0000,
        S_CMD0  = 12'b0000_1000_0000,
        S_CMD1  = 12'b0001_0000_0000,
        S_CMD2  = 12'b0010_0000_0000,
        S_WMUL  = 12'b0100_0000_0000,
        S_EMIT  = 12'b1000_0000_0000
    } state_t;

    state_t        state_reg, state_next;
    logic [WW-1:0] wheel_reg, wheel_next;
    logic [SW-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        wheel_next = wheel_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.msel   = wsm_pkg::MUL_FWD;
        cmd.wheel  = wheel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    wheel_next = '0;
                    state_next = S_SUM0;
                end
            end
            S_SUM0:
            begin
                cmd.msel   = wsm_pkg::MUL_FWD;
                state_next = S_SUM1;
            end
            S_SUM1:
            begin
                cmd.msel    = wsm_pkg::MUL_TURN;
                cmd.acc_fwd = 1'b1;
                state_next  = S_SUM2;
            end
            S_SUM2:
            begin
                cmd.acc_sum = 1'b1;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.exceed)
                begin
                    cmd.div_init = 1'b1;
                    step_next    = '0;
                    state_next   = S_DIV;
                end
                else if (status.last_wheel)
                begin
                    state_next = S_CMD0;
                end
                else
                begin
                    wheel_next = wheel_reg + WW'(1);
                    state_next = S_SUM0;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == SW'(wsm_pkg::DIV_STEPS - 1))
                    state_next = S_MIN;
                else
                    step_next = step_reg + SW'(1);
            end
            S_MIN:
            begin
                cmd.div_done = 1'b1;
                if (status.last_wheel)
                begin
                    state_next = S_CMD0;
                end
                else
                begin
                    wheel_next = wheel_reg + WW'(1);
                    state_next = S_SUM0;
                end
            end
            S_CMD0:
            begin
                cmd.msel   = wsm_pkg::MUL_CMDF;
                state_next = S_CMD1;
            end
            S_CMD1:
            begin
                cmd.msel      = wsm_pkg::MUL_CMDT;
                cmd.scale_fwd = 1'b1;
                state_next    = S_CMD2;
            end
            S_CMD2:
            begin
                cmd.scale_turn = 1'b1;
                wheel_next     = '0;
                state_next     = S_WMUL;
            end
            S_WMUL:
            begin
                cmd.msel   = wsm_pkg::MUL_WHEEL;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.msel = wsm_pkg::MUL_WHEEL;
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_wheel)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        wheel_next = wheel_reg + WW'(1);
                        state_next = S_WMUL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wheel_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wheel_reg <= wheel_next;
            step_reg  <= step_next;
        end
    end

endmodule

/* rtl/wsm_dp.sv */
// ----------------------------------------------------------------------------
// wsm_dp: datapath of the wheel speed mixer
// configuration registers, targets, shared multiplier, restoring divider,
// rounding and saturation, result register
// ----------------------------------------------------------------------------
module wsm_dp #(
    parameter int MAX_WHEELS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wsm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [wsm_pkg::MODE_W-1:0]          mode,
    input  logic signed [wsm_pkg::SPEED_W-1:0]  forward_speed,
    input  logic signed [wsm_pkg::SPEED_W-1:0]  turn_speed,
    input  wsm_pkg::wsm_cmd_t                   cmd,
    output wsm_pkg::wsm_status_t                status,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [wsm_pkg::WHEEL_W-1:0]         wheel_index,
    output logic signed [wsm_pkg::SPEED_W-1:0]  wheel_vel,
    output logic                                wheel_enable,
    output logic signed [wsm_pkg::SPEED_W-1:0]  command_forward,
    output logic signed [wsm_pkg::SPEED_W-1:0]  command_turn,
    output logic [wsm_pkg::SCALE_W-1:0]         desat_scale,
    output logic                                last
);

    localparam int IDX_W = (MAX_WHEELS > 1) ? $clog2(MAX_WHEELS) : 1;
    localparam int SW    = wsm_pkg::SPEED_W;
    localparam int CW    = wsm_pkg::SCALE_W;
    localparam int NW    = wsm_pkg::CNT_W;
    localparam int WW    = wsm_pkg::WHEEL_W;
    localparam int IW    = wsm_pkg::CFG_IDX_W;
    localparam int PRW   = wsm_pkg::PARAM_W;
    localparam int SUMW  = wsm_pkg::SUM_W;
    localparam int MAGW  = wsm_pkg::MAG_W;
    localparam int PW    = wsm_pkg::PROD_W;
    localparam int FW    = wsm_pkg::FRAC_W;
    localparam int QW    = wsm_pkg::QUO_W;
    localparam int LIMW  = SW + FW;
    localparam int BW    = CW + 1;

    // rounds a product to Q4.12, ties away from zero, and saturates
    function automatic logic [SW-1:0] round_sat(input logic signed [PW-1:0] p,
                                                input logic wheel);
        logic [PW-1:0] mag;
        logic [PW-1:0] r;
        logic [SW-1:0] res;
        mag = p[PW-1] ? PW'(-p) : PW'(p);
        if (wheel)
            r = (mag + (PW'(1) << (wsm_pkg::WHEEL_SHIFT - 1))) >> wsm_pkg::WHEEL_SHIFT;
        else
            r = (mag + (PW'(1) << (wsm_pkg::CMD_SHIFT - 1))) >> wsm_pkg::CMD_SHIFT;
        if (p[PW-1])
            res = (r > PW'(wsm_pkg::SPEED_MIN)) ? wsm_pkg::SPEED_MIN : SW'(PW'(0) - r);
        else
            res = (r > PW'(wsm_pkg::SPEED_MAX)) ? wsm_pkg::SPEED_MAX : r[SW-1:0];
        return res;
    endfunction

    // configuration
    logic [NW-1:0]  wheel_count_reg;
    logic [PRW-1:0] param_reg [MAX_WHEELS];

    // item state
    logic signed [SW-1:0]   tf_reg, tt_reg;
    logic                   stop_reg;
    logic [CW-1:0]          scale_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [SUMW-1:0] acc_reg;
    logic signed [SUMW-1:0] sum_reg [MAX_WHEELS];
    logic [MAGW-1:0]        mag_reg;
    logic [MAGW-1:0]        rem_reg, rem_next;
    logic [QW-1:0]          quo_reg;
    logic [SW-1:0]          cmdf_reg, cmdt_reg;

    // result register
    logic                   out_valid_reg;
    logic [WW-1:0]          out_index_reg;
    logic [SW-1:0]          out_speed_reg;
    logic                   out_enable_reg;
    logic [SW-1:0]          out_fwd_reg, out_turn_reg;
    logic [CW-1:0]          out_scale_reg;
    logic                   out_last_reg;

    logic [IDX_W-1:0]       idx;
    logic [PRW-1:0]         sel_param;
    logic signed [SW-1:0]   fc, tc;
    logic [SW-1:0]          mx_eff;
    logic [LIMW-1:0]        lim;
    logic [WW-1:0]          nlast;
    logic signed [SUMW-1:0] mul_a;
    logic signed [BW-1:0]   mul_b;
    logic signed [SUMW-1:0] sum_next, sum_abs;
    logic [MAGW:0]          trial;
    logic                   ge;

    assign idx       = cmd.wheel[IDX_W-1:0];
    assign sel_param = param_reg[idx];
    assign fc        = sel_param[PRW-1 -: SW];
    assign tc        = sel_param[PRW-SW-1 -: SW];
    assign mx_eff    = (sel_param[SW-1:0] == '0) ? SW'(1) : sel_param[SW-1:0];
    assign lim       = {mx_eff, {FW{1'b0}}};

    // index of the final wheel in use
    always_comb
    begin
        if (wheel_count_reg == '0)
            nlast = '0;
        else if (wheel_count_reg > NW'(MAX_WHEELS))
            nlast = WW'(MAX_WHEELS - 1);
        else
            nlast = WW'(wheel_count_reg - NW'(1));
    end

    always_comb
    begin
        unique case (cmd.msel)
            wsm_pkg::MUL_FWD:
            begin
                mul_a = SUMW'(fc);
                mul_b = BW'(tf_reg);
            end
            wsm_pkg::MUL_TURN:
            begin
                mul_a = SUMW'(tc);
                mul_b = BW'(tt_reg);
            end
            wsm_pkg::MUL_CMDF:
            begin
                mul_a = SUMW'(tf_reg);
                mul_b = signed'({1'b0, scale_reg});
            end
            wsm_pkg::MUL_CMDT:
            begin
                mul_a = SUMW'(tt_reg);
                mul_b = signed'({1'b0, scale_reg});
            end
            wsm_pkg::MUL_WHEEL:
            begin
                mul_a = sum_reg[idx];
                mul_b = signed'({1'b0, scale_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sum_next = acc_reg + $signed(prod_reg[SUMW-1:0]);
    assign sum_abs  = sum_next[SUMW-1] ? -sum_next : sum_next;

    // one restoring step, quotient bit per cycle
    assign trial    = {rem_reg, 1'b0};
    assign ge       = trial >= {1'b0, mag_reg};
    assign rem_next = ge ? MAGW'(trial - {1'b0, mag_reg}) : trial[MAGW-1:0];

    assign status.exceed     = mag_reg > MAGW'(lim);
    assign status.last_wheel = cmd.wheel == nlast;
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_count_reg <= wsm_pkg::WHEEL_COUNT_RESET;
            for (int i = 0; i < MAX_WHEELS; i++)
                param_reg[i] <= wsm_pkg::PARAM_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == IW'(wsm_pkg::REG_WHEEL_COUNT))
                wheel_count_reg <= cfg_data[NW-1:0];
            for (int i = 0; i < MAX_WHEELS; i++)
                if (cfg_index == IW'(wsm_pkg::REG_WHEEL_0) + IW'(i))
                    param_reg[i] <= cfg_data[PRW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tf_reg        <= '0;
            tt_reg        <= '0;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                stop_reg <= mode == wsm_pkg::MODE_STOP;
                unique case (wsm_pkg::mode_t'(mode))
                    wsm_pkg::MODE_BOTH:
                    begin
                        tf_reg <= forward_speed;
                        tt_reg <= turn_speed;
                    end
                    wsm_pkg::MODE_FWD:
                    begin
                        tf_reg <= forward_speed;
                    end
                    wsm_pkg::MODE_TURN:
                    begin
                        tt_reg <= turn_speed;
                    end
                    wsm_pkg::MODE_STOP:
                    begin
                        tf_reg <= '0;
                        tt_reg <= '0;
                    end
                    default:
                    begin
                        tf_reg <= tf_reg;
                    end
                endcase
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load)
            scale_reg <= wsm_pkg::SCALE_ONE;
        if (cmd.acc_fwd)
            acc_reg <= $signed(prod_reg[SUMW-1:0]);
        if (cmd.acc_sum)
        begin
            sum_reg[idx] <= sum_next;
            mag_reg      <= sum_abs[MAGW-1:0];
        end
        if (cmd.div_init)
        begin
            rem_reg <= MAGW'(lim);
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QW-2:0], ge};
        end
        if (cmd.div_done && (CW'(quo_reg) < scale_reg))
            scale_reg <= CW'(quo_reg);
        if (cmd.scale_fwd)
            cmdf_reg <= round_sat(prod_reg, 1'b0);
        if (cmd.scale_turn)
            cmdt_reg <= round_sat(prod_reg, 1'b0);
        if (cmd.emit)
        begin
            out_index_reg  <= cmd.wheel;
            out_speed_reg  <= round_sat(prod_reg, 1'b1);
            out_enable_reg <= !stop_reg;
            out_fwd_reg    <= cmdf_reg;
            out_turn_reg   <= cmdt_reg;
            out_scale_reg  <= scale_reg;
            out_last_reg   <= status.last_wheel;
        end
    end

    assign out_valid       = out_valid_reg;
    assign wheel_index     = out_index_reg;
    assign wheel_vel       = out_speed_reg;
    assign wheel_enable    = out_enable_reg;
    assign command_forward = out_fwd_reg;
    assign command_turn    = out_turn_reg;
    assign desat_scale     = out_scale_reg;
    assign last            = out_last_reg;

endmodule

/* rtl/wheel_speed_mixer_desaturate.sv */
// ----------------------------------------------------------------------------
// wheel_speed_mixer_desaturate: differential drive wheel mixer with common
// desaturation
// turns forward and turn commands into per-wheel speeds, scaled down together
// when any wheel would exceed its maximum
// ----------------------------------------------------------------------------
// one velocity command is taken at a time and gives one result per wheel in
// use, in wheel order, with last set on the final wheel. the single shared
// 33 x 17 multiplier forms every wheel sum, scaled command and scaled wheel
// speed in turn, and the restoring divider yields one scale bit a cycle for
// each wheel over its limit. a new command is taken as soon as the last
// wheel result sits in the output register, even if that result has not
// been taken yet.
// configuration registers may be written only while no command is in flight.
// stop (mode 3) clears both targets and gives disabled zero-speed results
// ----------------------------------------------------------------------------
module wheel_speed_mixer_desaturate #(
    parameter int MAX_WHEELS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [wsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wsm_pkg::CFG_DATA_W-1:0]  cfg_data,
    // velocity command requests
    wsm_cmd_if.sink                         command,
    // per-wheel result requests
    wsm_res_if.source                       result
);

    wsm_pkg::wsm_cmd_t    cmd;
    wsm_pkg::wsm_status_t status;
    logic                 in_ready;

    // sequencer: owns the wheel counter, division step count and phase
    wsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (command.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign command.ready = in_ready;

    // datapath: registers, shared multiplier, divider and result register
    wsm_dp #(
        .MAX_WHEELS (MAX_WHEELS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mode            (command.mode),
        .forward_speed   (command.forward_speed),
        .turn_speed      (command.turn_speed),
        .cmd             (cmd),
        .status          (status),
        .out_ready       (result.ready),
        .out_valid       (result.valid),
        .wheel_index     (result.wheel_index),
        .wheel_vel       (result.wheel_vel),
        .wheel_enable    (result.wheel_enable),
        .command_forward (result.command_forward),
        .command_turn    (result.command_turn),
        .desat_scale     (result.desat_scale),
        .last            (result.last)
    );

endmodule

/* rtl/wsm_checker.sv */
// ----------------------------------------------------------------------------
// wsm_checker: port-level checks of the wheel speed mixer
// watches the result channel over time, attached to the top level by bind
// ----------------------------------------------------------------------------
module wsm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            result_valid,
    input logic                            result_ready,
    input logic [wsm_pkg::WHEEL_W-1:0]     wheel_index,
    input logic [wsm_pkg::SPEED_W-1:0]     wheel_vel,
    input logic                            wheel_enable,
    input logic [wsm_pkg::SPEED_W-1:0]     command_forward,
    input logic [wsm_pkg::SPEED_W-1:0]     command_turn,
    input logic [wsm_pkg::SCALE_W-1:0]     desat_scale,
    input logic                            last
);

    // a stalled result request stays offered
    ap_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result request dropped while stalled");

    // a stalled result request keeps its wheel index, wheel speed and last flag
    ap_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            $stable(wheel_index) && $stable(wheel_vel) && $stable(last))
        else $error("result payload changed while stalled");

    // a stopped wheel carries zero speed, zero commands and unit scale
    ap_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !wheel_enable |->
            wheel_vel == '0 && command_forward == '0 && command_turn == '0 &&
            desat_scale == wsm_pkg::SCALE_ONE)
        else $error("stopped wheel result not zeroed");

    // desaturation only ever shrinks
    ap_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> desat_scale <= wsm_pkg::SCALE_ONE)
        else $error("speed scale above one");

    // the highest wheel is always the final one of a command
    ap_top_wheel_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && wheel_index == wsm_pkg::WHEEL_W'(3) |-> last)
        else $error("highest wheel result without last");

endmodule

bind wheel_speed_mixer_desaturate wsm_checker u_wsm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .wheel_index     (result.wheel_index),
    .wheel_vel       (result.wheel_vel),
    .wheel_enable    (result.wheel_enable),
    .command_forward (result.command_forward),
    .command_turn    (result.command_turn),
    .desat_scale     (result.desat_scale),
    .last            (result.last)
);

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: wheel speed mixer with common desaturation
// drives velocity requests and configuration writes into the mixer, rebuilds
// every per-wheel result with its own fixed-point model of the mixer and
// compares each result field by field, under changing sender and receiver
// idle patterns, a long receiver hold-off and several wheel settings
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF         = 5;
    localparam int WHEELS_MAX       = 4;
    localparam int RESET_CYCLES     = 4;
    localparam int RANDOM_PER_PHASE = 40;
    localparam int SETTING_EVERY    = 15;
    localparam int HOLD_CYCLES      = 300;
    localparam int TAIL_CYCLES      = 100;     // above the length of the slowest request
    localparam int RUN_LIMIT_NS     = 5_000_000;

    // register indexes past the end of the map, writes there must be ignored
    localparam logic [wsm_pkg::CFG_IDX_W-1:0] REG_BEYOND = 3'd5;

    // one result as the mixer should present it
    typedef struct {
        logic [wsm_pkg::WHEEL_W-1:0] wheel_index;
        logic [wsm_pkg::SPEED_W-1:0] wheel_vel;
        logic                        wheel_enable;
        logic [wsm_pkg::SPEED_W-1:0] command_forward;
        logic [wsm_pkg::SPEED_W-1:0] command_turn;
        logic [wsm_pkg::SCALE_W-1:0] desat_scale;
        logic                        last;
    } wheel_result_t;

    // one step of stimulus: a register write or a velocity request, the
    // latter optionally carrying hand-computed values shared by all wheels
    typedef struct {
        logic                               is_cfg;
        logic [wsm_pkg::CFG_IDX_W-1:0]      reg_idx;
        logic [wsm_pkg::CFG_DATA_W-1:0]     reg_data;
        wsm_pkg::mode_t                     mode;
        logic signed [wsm_pkg::SPEED_W-1:0] fwd;
        logic signed [wsm_pkg::SPEED_W-1:0] turn;
        logic                               typed;
        logic [wsm_pkg::SPEED_W-1:0]        exp_speed;
        logic                               exp_enable;
        logic [wsm_pkg::SPEED_W-1:0]        exp_fwd;
        logic [wsm_pkg::SPEED_W-1:0]        exp_turn;
        logic [wsm_pkg::SCALE_W-1:0]        exp_scale;
    } stim_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [wsm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [wsm_pkg::CFG_DATA_W-1:0] cfg_data;

    wsm_cmd_if command_ch ();
    wsm_res_if result_ch ();

    wheel_speed_mixer_desaturate #(
        .MAX_WHEELS (WHEELS_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .command   (command_ch),
        .result    (result_ch)
    );

    // mirror of the mixer's configuration and stored targets
    logic [wsm_pkg::CNT_W-1:0]          cfg_wheels;
    logic [wsm_pkg::PARAM_W-1:0]        cfg_params [WHEELS_MAX];
    logic signed [wsm_pkg::SPEED_W-1:0] tgt_forward;
    logic signed [wsm_pkg::SPEED_W-1:0] tgt_turn;

    // results still owed by the mixer, oldest first
    wheel_result_t wheel_results_due [$];
    stim_row_t     directed_rows [$];

    // idle percentages of the two sides, and the receiver hold-off request
    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_request;

    int error_count  = 0;
    int results_seen = 0;
    int scaled_seen  = 0;
    int requests_sent;
    int register_writes;

    // ------------------------------------------------------------------
    // fixed-point helpers of the mixer model
    // ------------------------------------------------------------------

    // round to nearest with ties away from zero, then drop sh bits
    function automatic longint round_half_away(input longint v, input int sh);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r   = (mag + (longint'(1) << (sh - 1))) >> sh;
        return (v < 0) ? -r : r;
    endfunction

    function automatic logic [wsm_pkg::SPEED_W-1:0] clamp16(input longint v);
        if (v > 32767)
            return wsm_pkg::SPEED_MAX;
        if (v < -32768)
            return wsm_pkg::SPEED_MIN;
        return v[wsm_pkg::SPEED_W-1:0];
    endfunction

    // updates the targets for one velocity request and returns the wheel
    // results it gives, one per wheel in use
    function automatic int mix_wheels(input wsm_pkg::mode_t mode,
                                      input logic signed [wsm_pkg::SPEED_W-1:0] fwd,
                                      input logic signed [wsm_pkg::SPEED_W-1:0] turn,
                                      output wheel_result_t res [WHEELS_MAX]);
        longint sums [WHEELS_MAX];
        longint scale;
        longint fc;
        longint tc;
        longint mx;
        longint mag;
        int     n;
        logic   stop;
        scale = longint'(wsm_pkg::SCALE_ONE);
        stop  = (mode == wsm_pkg::MODE_STOP);
        if (mode == wsm_pkg::MODE_BOTH || mode == wsm_pkg::MODE_FWD)
            tgt_forward = fwd;
        if (mode == wsm_pkg::MODE_BOTH || mode == wsm_pkg::MODE_TURN)
            tgt_turn = turn;
        if (stop)
        begin
            tgt_forward = '0;
            tgt_turn    = '0;
        end
        // a count of zero still drives one wheel, counts above the top clip
        n = int'(cfg_wheels);
        if (n == 0)
            n = 1;
        if (n > WHEELS_MAX)
            n = WHEELS_MAX;
        // exact Q9.24 sums, smallest candidate scale over the wheels that exceed
        for (int k = 0; k < n; k++)
        begin
            fc = longint'($signed(cfg_params[k][47:32]));
            tc = longint'($signed(cfg_params[k][31:16]));
            mx = longint'(cfg_params[k][15:0]);
            if (mx == 0)
                mx = 1;     // a zero maximum counts as one lsb
            sums[k] = fc * longint'(tgt_forward) + tc * longint'(tgt_turn);
            mag = (sums[k] < 0) ? -sums[k] : sums[k];
            if (mag > (mx << wsm_pkg::FRAC_W))
            begin
                if ((mx << wsm_pkg::WHEEL_SHIFT) / mag < scale)
                    scale = (mx << wsm_pkg::WHEEL_SHIFT) / mag;
            end
        end
        for (int k = 0; k < n; k++)
        begin
            res[k].wheel_index = wsm_pkg::WHEEL_W'(k);
            res[k].last        = (k == n - 1);
            if (stop)
            begin
                res[k].wheel_vel       = '0;
                res[k].wheel_enable    = 1'b0;
                res[k].command_forward = '0;
                res[k].command_turn    = '0;
                res[k].desat_scale     = wsm_pkg::SCALE_ONE;
            end
            else
            begin
                res[k].wheel_vel       =
                    clamp16(round_half_away(sums[k] * scale, wsm_pkg::WHEEL_SHIFT));
                res[k].wheel_enable    = 1'b1;
                res[k].command_forward =
                    clamp16(round_half_away(longint'(tgt_forward) * scale,
                                            wsm_pkg::CMD_SHIFT));
                res[k].command_turn    =
                    clamp16(round_half_away(longint'(tgt_turn) * scale,
                                            wsm_pkg::CMD_SHIFT));
                res[k].desat_scale     = scale[wsm_pkg::SCALE_W-1:0];
            end
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // stimulus rows
    // ------------------------------------------------------------------

    function automatic stim_row_t cmd_row(input wsm_pkg::mode_t mode,
                                          input logic signed [wsm_pkg::SPEED_W-1:0] fwd,
                                          input logic signed [wsm_pkg::SPEED_W-1:0] turn);
        stim_row_t r;
        r.is_cfg     = 1'b0;
        r.reg_idx    = wsm_pkg::REG_WHEEL_COUNT;
        r.reg_data   = '0;
        r.mode       = mode;
        r.fwd        = fwd;
        r.turn       = turn;
        r.typed      = 1'b0;
        r.exp_speed  = '0;
        r.exp_enable = 1'b0;
        r.exp_fwd    = '0;
        r.exp_turn   = '0;
        r.exp_scale  = '0;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input wsm_pkg::mode_t mode,
                                            input logic signed [wsm_pkg::SPEED_W-1:0] fwd,
                                            input logic signed [wsm_pkg::SPEED_W-1:0] turn,
                                            input logic [wsm_pkg::SPEED_W-1:0] speed,
                                            input logic enable,
                                            input logic [wsm_pkg::SPEED_W-1:0] cmd_fwd,
                                            input logic [wsm_pkg::SPEED_W-1:0] cmd_turn,
                                            input logic [wsm_pkg::SCALE_W-1:0] scale);
        stim_row_t r;
        r            = cmd_row(mode, fwd, turn);
        r.typed      = 1'b1;
        r.exp_speed  = speed;
        r.exp_enable = enable;
        r.exp_fwd    = cmd_fwd;
        r.exp_turn   = cmd_turn;
        r.exp_scale  = scale;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [wsm_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [wsm_pkg::CFG_DATA_W-1:0] data);
        stim_row_t r;
        r          = cmd_row(wsm_pkg::MODE_BOTH, '0, '0);
        r.is_cfg   = 1'b1;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    function automatic logic [wsm_pkg::SPEED_W-1:0] extreme_speed();
        case ($urandom_range(4))
            0:       return wsm_pkg::SPEED_MAX;
            1:       return wsm_pkg::SPEED_MIN;
            2:       return 16'h0000;
            3:       return 16'h0001;
            default: return 16'hFFFF;
        endcase
    endfunction

    // mostly moderate speeds so that scaling comes and goes, some full range or extreme
    function automatic logic [wsm_pkg::SPEED_W-1:0] random_speed();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return wsm_pkg::SPEED_W'($urandom_range(16'h4000)) - 16'h2000;
            5, 6, 7:       return wsm_pkg::SPEED_W'($urandom);
            default:       return extreme_speed();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // drivers, all entered and left at a falling edge
    // ------------------------------------------------------------------

    // register write on the next rising edge, mirrored into the model
    task automatic write_register(input logic [wsm_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [wsm_pkg::CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        if (idx == wsm_pkg::REG_WHEEL_COUNT)
            cfg_wheels = data[wsm_pkg::CNT_W-1:0];
        else if (idx >= wsm_pkg::REG_WHEEL_0 && idx <= wsm_pkg::REG_WHEEL_3)
            cfg_params[idx - wsm_pkg::REG_WHEEL_0] = data[wsm_pkg::PARAM_W-1:0];
        // indexes past the map leave the mirror alone
        register_writes++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // offer one velocity request and predict its results once it is taken;
    // valid stays high on return so a following request can go back to back
    task automatic send_command(input stim_row_t row);
        wheel_result_t predicted [WHEELS_MAX];
        int            n;
        cfg_we = 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            command_ch.valid = 1'b0;
            @(negedge clk);
        end
        command_ch.valid         = 1'b1;
        command_ch.mode          = row.mode;
        command_ch.forward_speed = row.fwd;
        command_ch.turn_speed    = row.turn;
        @(posedge clk);
        while (!command_ch.ready)
            @(posedge clk);
        n = mix_wheels(row.mode, row.fwd, row.turn, predicted);
        for (int k = 0; k < n; k++)
        begin
            // hand-computed rows overrule the model on the value fields
            if (row.typed)
            begin
                predicted[k].wheel_vel       = row.exp_speed;
                predicted[k].wheel_enable    = row.exp_enable;
                predicted[k].command_forward = row.exp_fwd;
                predicted[k].command_turn    = row.exp_turn;
                predicted[k].desat_scale     = row.exp_scale;
            end
            wheel_results_due.push_back(predicted[k]);
        end
        requests_sent++;
        @(negedge clk);
    endtask

    // stop offering and wait until every owed result has come back; every
    // request gives at least one result, so the mixer is idle afterwards
    task automatic wait_results_drained();
        command_ch.valid = 1'b0;
        while (wheel_results_due.size() != 0)
            @(negedge clk);
    endtask

    // a fresh random wheel setting; each wheel gets moderate, fully random or
    // extreme coefficients and maximum, sometimes with a write past the map
    task automatic pick_new_setting();
        logic [wsm_pkg::SPEED_W-1:0] fc;
        logic [wsm_pkg::SPEED_W-1:0] tc;
        logic [wsm_pkg::SPEED_W-1:0] mx;
        write_register(wsm_pkg::REG_WHEEL_COUNT,
                       wsm_pkg::CFG_DATA_W'($urandom_range((1 << wsm_pkg::CNT_W) - 1)));
        for (int w = 0; w < WHEELS_MAX; w++)
        begin
            case ($urandom_range(2))
                0:
                begin
                    fc = wsm_pkg::SPEED_W'($urandom_range(16'h3000)) - 16'h1800;
                    tc = wsm_pkg::SPEED_W'($urandom_range(16'h1000)) - 16'h0800;
                    mx = wsm_pkg::SPEED_W'($urandom_range(16'h3000, 16'h0400));
                end
                1:
                begin
                    {fc, tc, mx} = wsm_pkg::PARAM_W'({$urandom, $urandom});
                end
                default:
                begin
                    fc = extreme_speed();
                    tc = extreme_speed();
                    mx = extreme_speed();
                end
            endcase
            write_register(wsm_pkg::CFG_IDX_W'(wsm_pkg::REG_WHEEL_0 + w), {fc, tc, mx});
        end
        if ($urandom_range(2) == 0)
            write_register(wsm_pkg::CFG_IDX_W'(REG_BEYOND + $urandom_range(2)),
                           wsm_pkg::CFG_DATA_W'({$urandom, $urandom}));
    endtask

    // ------------------------------------------------------------------
    // clock, limit
    // ------------------------------------------------------------------

    initial
    begin : clock_gen
        clk = 1'b0;
        forever
            #CLK_HALF clk = ~clk;
    end

    initial
    begin : run_limit
        #RUN_LIMIT_NS;
        $display("timeout: %0d results still owed", wheel_results_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: ready pattern, with a long hold-off on request
    // ------------------------------------------------------------------

    initial
    begin : result_ready_drive
        int   hold_left;
        logic hold_taken;
        hold_left       = 0;
        hold_taken      = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready = 1'b0;
            end
            else
            begin
                result_ch.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic void check_field(input string what,
                                        input logic [wsm_pkg::SPEED_W-1:0] want,
                                        input logic [wsm_pkg::SPEED_W-1:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        end
    endfunction

    // every taken result is matched against the oldest owed one
    always @(posedge clk)
    begin : result_check
        wheel_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (result_ch.desat_scale != wsm_pkg::SCALE_ONE)
                scaled_seen++;
            if (wheel_results_due.size() == 0)
            begin
                error_count++;
                $display("%0t: result for wheel %0d with no request owing it",
                         $time, result_ch.wheel_index);
            end
            else
            begin
                want = wheel_results_due.pop_front();
                check_field("wheel_index", want.wheel_index, result_ch.wheel_index);
                check_field("wheel_vel", want.wheel_vel, result_ch.wheel_vel);
                check_field("wheel_enable", want.wheel_enable, result_ch.wheel_enable);
                check_field("command_forward", want.command_forward,
                            result_ch.command_forward);
                check_field("command_turn", want.command_turn, result_ch.command_turn);
                check_field("desat_scale", want.desat_scale, result_ch.desat_scale);
                check_field("last", want.last, result_ch.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        wsm_pkg::mode_t m;
        // every input known from time zero, reset held low
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = wsm_pkg::REG_WHEEL_COUNT;
        cfg_data                 = '0;
        command_ch.valid         = 1'b0;
        command_ch.mode          = wsm_pkg::MODE_BOTH;
        command_ch.forward_speed = '0;
        command_ch.turn_speed    = '0;
        send_idle_pct            = 0;
        recv_stall_pct           = 0;
        hold_request             = 1'b0;
        requests_sent            = 0;
        register_writes          = 0;
        // mirror starts at the reset values
        cfg_wheels  = wsm_pkg::WHEEL_COUNT_RESET;
        tgt_forward = '0;
        tgt_turn    = '0;
        for (int w = 0; w < WHEELS_MAX; w++)
            cfg_params[w] = wsm_pkg::PARAM_RESET;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // directed part; the first rows run on the reset setting (two wheels,
        // forward coefficient one, no turn, maximum one), so the values can be
        // worked out by hand and hold for both wheels
        directed_rows = '{
            // plain request at the limit, no scaling
            typed_row(wsm_pkg::MODE_BOTH, 16'h1000, 16'h0000,
                      16'h1000, 1'b1, 16'h1000, 16'h0000, 16'h8000),
            // twice the limit halves everything, turn 2.5 lsb rounds away to 3
            typed_row(wsm_pkg::MODE_BOTH, 16'h2000, 16'h0005,
                      16'h1000, 1'b1, 16'h1000, 16'h0003, 16'h4000),
            // stop ignores the request and gives disabled zero results
            typed_row(wsm_pkg::MODE_STOP, 16'h7FFF, 16'h8000,
                      16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h8000),
            // both extremes of the speed fields
            typed_row(wsm_pkg::MODE_BOTH, 16'h7FFF, 16'h8000,
                      16'h1000, 1'b1, 16'h1000, 16'hF000, 16'h1000),
            typed_row(wsm_pkg::MODE_BOTH, 16'h8000, 16'h7FFF,
                      16'hF000, 1'b1, 16'hF000, 16'h1000, 16'h1000),
            // forward only keeps the stored turn target
            typed_row(wsm_pkg::MODE_FWD, 16'h0800, 16'h1234,
                      16'h0800, 1'b1, 16'h0800, 16'h7FFF, 16'h8000),
            // turn only keeps the stored forward target
            typed_row(wsm_pkg::MODE_TURN, 16'h1111, 16'h0100,
                      16'h0800, 1'b1, 16'h0800, 16'h0100, 16'h8000),
            typed_row(wsm_pkg::MODE_BOTH, 16'h0000, 16'h0000,
                      16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h8000),
            // four wheels: opposite turn coefficients, two wheels at the
            // coefficient extremes, the second of them with a zero maximum
            cfg_row(wsm_pkg::REG_WHEEL_COUNT, 48'd4),
            cfg_row(wsm_pkg::REG_WHEEL_0, {16'h1000, 16'hFC00, 16'h2000}),
            cfg_row(wsm_pkg::REG_WHEEL_1, {16'h1000, 16'h0400, 16'h2000}),
            cfg_row(wsm_pkg::REG_WHEEL_2, {16'h7FFF, 16'h8000, 16'hFFFF}),
            cfg_row(wsm_pkg::REG_WHEEL_3, {16'h8000, 16'h7FFF, 16'h0000}),
            cmd_row(wsm_pkg::MODE_BOTH, 16'h1000, 16'h2000),
            cmd_row(wsm_pkg::MODE_BOTH, 16'h7FFF, 16'h7FFF),
            cmd_row(wsm_pkg::MODE_BOTH, 16'h8000, 16'h8000),
            cmd_row(wsm_pkg::MODE_FWD, 16'h0400, 16'h5555),
            cmd_row(wsm_pkg::MODE_TURN, 16'hAAAA, 16'hFFFF),
            cmd_row(wsm_pkg::MODE_STOP, 16'h1234, 16'h4321),
            // a tiny wheel under a huge maximum, so it stays within its limit
            cfg_row(wsm_pkg::REG_WHEEL_3, {16'h0010, 16'h0000, 16'hFFFF}),
            cmd_row(wsm_pkg::MODE_BOTH, 16'h7FFF, 16'h0000),
            // wheel count of zero drives a single wheel
            cfg_row(wsm_pkg::REG_WHEEL_COUNT, 48'd0),
            cmd_row(wsm_pkg::MODE_BOTH, 16'h0001, 16'hFFFF),
            // wheel count past the top is clipped to four
            cfg_row(wsm_pkg::REG_WHEEL_COUNT, 48'd7),
            cmd_row(wsm_pkg::MODE_BOTH, 16'hFFFF, 16'h0001),
            // writes past the register map change nothing
            cfg_row(REG_BEYOND, 48'hFFFF_FFFF_FFFF),
            cfg_row(wsm_pkg::CFG_IDX_W'(REG_BEYOND + 1), 48'hFFFF_FFFF_FFFF),
            cfg_row(wsm_pkg::CFG_IDX_W'(REG_BEYOND + 2), 48'hFFFF_FFFF_FFFF),
            cmd_row(wsm_pkg::MODE_TURN, 16'h0000, 16'h7FFF),
            // three wheels, one all ones, one all zeros
            cfg_row(wsm_pkg::REG_WHEEL_COUNT, 48'd3),
            cfg_row(wsm_pkg::REG_WHEEL_0, 48'hFFFF_FFFF_FFFF),
            cfg_row(wsm_pkg::REG_WHEEL_1, 48'h0000_0000_0000),
            cmd_row(wsm_pkg::MODE_BOTH, 16'h4000, 16'hC000),
            cmd_row(wsm_pkg::MODE_FWD, 16'h8000, 16'h0000),
            // single wheel just over its limit
            cfg_row(wsm_pkg::REG_WHEEL_COUNT, 48'd1),
            cfg_row(wsm_pkg::REG_WHEEL_0, wsm_pkg::PARAM_RESET),
            cmd_row(wsm_pkg::MODE_BOTH, 16'h1001, 16'h0000)
        };
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                wait_results_drained();
                write_register(directed_rows[i].reg_idx, directed_rows[i].reg_data);
            end
            else
            begin
                send_command(directed_rows[i]);
            end
        end

        // random part in four idle phases, new setting every few requests
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                if (i % SETTING_EVERY == 0)
                begin
                    wait_results_drained();
                    pick_new_setting();
                end
                // result side holds off while requests keep coming, the
                // mixer fills up and has to stall its input
                if (p == 0 && i == SETTING_EVERY)
                    hold_request = 1'b1;
                // sender waits for the mixer to empty completely mid-setting
                if (p == 1 && i == SETTING_EVERY + 5)
                    wait_results_drained();
                m = wsm_pkg::mode_t'($urandom_range(wsm_pkg::MODE_STOP));
                if (m == wsm_pkg::MODE_STOP && $urandom_range(1) == 0)
                    m = wsm_pkg::MODE_BOTH;      // keep stops rarer so targets build up
                send_command(cmd_row(m, random_speed(), random_speed()));
            end
        end

        // everything owed back, then some quiet time for stray results
        wait_results_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("covered %0d velocity requests and %0d register writes over several settings",
                 requests_sent, register_writes);
        $display("checked %0d wheel results, %0d of them desaturated, %0d mismatches",
                 results_seen, scaled_seen, error_count);
        if (error_count == 0 && wheel_results_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/wsm_pkg.sv
rtl/wsm_if.sv
rtl/wsm_ctrl.sv
rtl/wsm_dp.sv
rtl/wheel_speed_mixer_desaturate.sv
rtl/wsm_checker.sv
dv/testbench.sv
